// ===== rtl/core/ntc_pkg.sv =====
// shared types, constants and tables of the ntc temperature conversion unit
package ntc_pkg;

  // sizing of the accumulator and the lookup
  localparam int MAX_SAMPLES   = 100;
  localparam int TABLE_ENTRIES = 100;
  localparam int ROM_SIZE      = 100;
  localparam int TABLE_BIAS    = 10;
  localparam int SHORT_TEMP    = 100;
  localparam int BLEND_DIV     = 5;
  localparam int TABLE_LEN     = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;

  // divide by five as multiply by 6554 / 2^15, exact for blends below 16384
  localparam int BLEND_RECIP   = 6554;
  localparam int BLEND_SHIFT   = 15;

  // field and register widths
  localparam int ADC_W   = 10;
  localparam int TEMP_W  = 7;
  localparam int FAULT_W = 2;
  localparam int SUM_W   = 17;
  localparam int CNT_W   = 7;
  localparam int BLEND_W = 13;
  localparam int PROD_W  = 26;
  localparam int DCNT_W  = 5;

  // request codes
  localparam logic OPN_SAMPLE = 1'b0;
  localparam logic OPN_EVAL   = 1'b1;

  // fault codes
  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_OPEN  = 2'd1,
    FAULT_SHORT = 2'd2
  } fault_t;

  // program addresses
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV_AVG,
    ST_BLEND,
    ST_FILT,
    ST_LOOK_INIT,
    ST_LOOK,
    ST_TH,
    ST_HYST
  } step_t;

  // datapath actions
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD_AVG,
    OP_DIV_STEP,
    OP_LOAD_BLEND,
    OP_SET_FILT,
    OP_IDX_CLR,
    OP_IDX_INC,
    OP_SET_TH,
    OP_HYST
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_NO_EVAL,
    CND_CNT_ZERO,
    CND_DIV_BUSY,
    CND_NOT_HIT,
    CND_OUT_BUSY
  } cond_t;

  // one control word
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt;
    step_t fall;
  } ctrl_t;

  // status flags from the datapath to the sequencer
  typedef struct packed {
    logic no_eval;
    logic cnt_zero;
    logic div_busy;
    logic not_hit;
    logic out_busy;
  } stat_t;

  // divider controls
  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  // thermistor adc table, ascending, before the bias is removed
  localparam logic [ADC_W-1:0] ROM_BASE [ROM_SIZE] = '{
    10'd139, 10'd145, 10'd152, 10'd158, 10'd165, 10'd172, 10'd179, 10'd187, 10'd194, 10'd202,
    10'd210, 10'd218, 10'd226, 10'd234, 10'd243, 10'd251, 10'd260, 10'd269, 10'd278, 10'd288,
    10'd297, 10'd306, 10'd316, 10'd326, 10'd336, 10'd346, 10'd356, 10'd366, 10'd376, 10'd387,
    10'd397, 10'd407, 10'd418, 10'd428, 10'd439, 10'd449, 10'd460, 10'd470, 10'd480, 10'd491,
    10'd501, 10'd511, 10'd522, 10'd532, 10'd542, 10'd552, 10'd562, 10'd572, 10'd581, 10'd591,
    10'd601, 10'd610, 10'd619, 10'd628, 10'd637, 10'd646, 10'd655, 10'd664, 10'd672, 10'd680,
    10'd689, 10'd697, 10'd704, 10'd712, 10'd720, 10'd727, 10'd735, 10'd742, 10'd749, 10'd755,
    10'd762, 10'd769, 10'd775, 10'd781, 10'd787, 10'd793, 10'd799, 10'd805, 10'd810, 10'd816,
    10'd821, 10'd826, 10'd831, 10'd836, 10'd841, 10'd845, 10'd850, 10'd854, 10'd859, 10'd863,
    10'd867, 10'd871, 10'd875, 10'd879, 10'd882, 10'd886, 10'd889, 10'd893, 10'd896, 10'd899
  };

  // table entry with clamped index and bias removed
  function automatic logic [ADC_W-1:0] table_at(input logic [TEMP_W-1:0] i);
    logic [TEMP_W-1:0] j;
    j = (i >= TEMP_W'(ROM_SIZE)) ? TEMP_W'(ROM_SIZE - 1) : i;
    return ROM_BASE[j] - ADC_W'(TABLE_BIAS);
  endfunction

endpackage

// ===== rtl/core/ntc_div.sv =====
// iterative restoring divider, one quotient bit per step
module ntc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ntc_pkg::div_ctl_t                ctl,
  input  logic [ntc_pkg::SUM_W-1:0]        dividend,
  input  logic [ntc_pkg::CNT_W-1:0]        divisor,
  output logic [ntc_pkg::SUM_W-1:0]        quotient,
  output logic                             busy
);

  logic [ntc_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [ntc_pkg::SUM_W-1:0]  quo_r, quo_nxt;
  logic [ntc_pkg::CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [ntc_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [ntc_pkg::CNT_W:0]    shifted;
  logic [ntc_pkg::CNT_W:0]    diff;
  logic                       ge;

  // trial subtraction of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem_r, quo_r[ntc_pkg::SUM_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = (shifted >= {1'b0, dvs_r});
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = ntc_pkg::DCNT_W'(ntc_pkg::SUM_W);
    end else if (ctl.step) begin
      rem_nxt = ge ? diff[ntc_pkg::CNT_W-1:0] : shifted[ntc_pkg::CNT_W-1:0];
      quo_nxt = {quo_r[ntc_pkg::SUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  // more steps follow the current one
  assign busy     = (cnt_r != ntc_pkg::DCNT_W'(1));

endmodule

// ===== rtl/core/ntc_dp.sv =====
// datapath: accumulator, filter, table search, hysteresis and result register
module ntc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ntc_pkg::ctrl_t                ctrl,
  output ntc_pkg::stat_t                stat,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [ntc_pkg::ADC_W-1:0]     in_adc_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ntc_pkg::TEMP_W-1:0]    out_temperature,
  output logic [ntc_pkg::FAULT_W-1:0]   out_fault,
  output logic [ntc_pkg::ADC_W-1:0]     out_filtered_adc
);

  logic [ntc_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [ntc_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [ntc_pkg::ADC_W-1:0]   filt_r, filt_nxt;
  logic [ntc_pkg::TEMP_W-1:0]  rep_r, rep_nxt;
  logic [ntc_pkg::TEMP_W-1:0]  idx_r, idx_nxt;
  logic [ntc_pkg::ADC_W-1:0]   th_r, th_nxt;
  logic [ntc_pkg::BLEND_W-1:0] blend_r, blend_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ntc_pkg::TEMP_W-1:0]  out_temp_r, out_temp_nxt;
  ntc_pkg::fault_t             out_fault_r, out_fault_nxt;
  ntc_pkg::fault_t             fault_new;
  logic [ntc_pkg::ADC_W-1:0]   out_filt_r, out_filt_nxt;

  logic                        in_acc;
  logic                        out_busy;
  logic                        hit;
  logic                        idx_up;
  logic [ntc_pkg::TEMP_W-1:0]  lo_addr, hi_addr;
  logic [ntc_pkg::ADC_W-1:0]   lo_val, hi_val, quarter;
  logic [ntc_pkg::ADC_W-1:0]   avg, blend_q;
  logic [ntc_pkg::BLEND_W-1:0] blend;
  logic [ntc_pkg::PROD_W-1:0]  prod;
  ntc_pkg::div_ctl_t           div_ctl;
  logic [ntc_pkg::SUM_W-1:0]   div_dividend;
  logic [ntc_pkg::CNT_W-1:0]   div_divisor;
  logic [ntc_pkg::SUM_W-1:0]   div_quo;
  logic                        div_busy;

  assign in_ready = (ctrl.op == ntc_pkg::OP_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_busy = out_valid_r && !out_ready;

  // blend of old filtered value and new average, 2*old + 3*avg
  assign avg     = div_quo[ntc_pkg::ADC_W-1:0];
  assign blend   = ntc_pkg::BLEND_W'({filt_r, 1'b0}) + ntc_pkg::BLEND_W'(avg)
                 + ntc_pkg::BLEND_W'({avg, 1'b0});

  // registered blend divided by five with a reciprocal multiply
  assign prod    = ntc_pkg::PROD_W'(blend_r) * ntc_pkg::PROD_W'(ntc_pkg::BLEND_RECIP);
  assign blend_q = prod[ntc_pkg::BLEND_SHIFT+ntc_pkg::ADC_W-1:ntc_pkg::BLEND_SHIFT];

  // divider averages the held samples
  always_comb begin
    div_ctl.load = (ctrl.op == ntc_pkg::OP_LOAD_AVG);
    div_ctl.step = (ctrl.op == ntc_pkg::OP_DIV_STEP);
  end
  assign div_dividend = sum_r;
  assign div_divisor  = count_r;

  ntc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .busy     (div_busy)
  );

  // search stops at the first larger entry or past the end of the table
  assign hit = (idx_r == ntc_pkg::TEMP_W'(ntc_pkg::TABLE_LEN))
            || (filt_r < ntc_pkg::table_at(idx_r));

  // hysteresis threshold from the two neighbouring entries
  always_comb begin
    idx_up  = (idx_r > rep_r);
    lo_addr = idx_up ? rep_r : (idx_r - 1'b1);
    hi_addr = lo_addr + 1'b1;
    lo_val  = ntc_pkg::table_at(lo_addr);
    hi_val  = ntc_pkg::table_at(hi_addr);
    quarter = (hi_val - lo_val) >> 2;
  end

  // new reported reading and fault
  always_comb begin
    rep_nxt   = rep_r;
    fault_new = ntc_pkg::FAULT_NONE;
    if (idx_r == '0) begin
      rep_nxt   = '0;
      fault_new = ntc_pkg::FAULT_OPEN;
    end else if (idx_r >= ntc_pkg::TEMP_W'(ntc_pkg::TABLE_LEN)) begin
      rep_nxt   = ntc_pkg::TEMP_W'(ntc_pkg::SHORT_TEMP);
      fault_new = ntc_pkg::FAULT_SHORT;
    end else if (idx_r > rep_r) begin
      rep_nxt = (filt_r >= th_r) ? idx_r : (idx_r - 1'b1);
    end else if (idx_r < rep_r) begin
      rep_nxt = (filt_r <= th_r) ? idx_r : (idx_r + 1'b1);
    end
  end

  // register updates per control word
  always_comb begin
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    filt_nxt      = filt_r;
    idx_nxt       = idx_r;
    th_nxt        = th_r;
    blend_nxt     = blend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_temp_nxt  = out_temp_r;
    out_fault_nxt = out_fault_r;
    out_filt_nxt  = out_filt_r;
    case (ctrl.op)
      ntc_pkg::OP_IDLE: begin
        if (in_acc && (in_operation == ntc_pkg::OPN_SAMPLE)
            && (count_r < ntc_pkg::CNT_W'(ntc_pkg::MAX_SAMPLES))) begin
          sum_nxt   = sum_r + ntc_pkg::SUM_W'(in_adc_sample);
          count_nxt = count_r + 1'b1;
        end
      end
      ntc_pkg::OP_LOAD_AVG: begin
        sum_nxt   = '0;
        count_nxt = '0;
      end
      ntc_pkg::OP_LOAD_BLEND: blend_nxt = blend;
      ntc_pkg::OP_SET_FILT: filt_nxt = blend_q;
      ntc_pkg::OP_IDX_CLR:  idx_nxt  = '0;
      ntc_pkg::OP_IDX_INC: begin
        if (!hit) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ntc_pkg::OP_SET_TH:   th_nxt = idx_up ? (lo_val + quarter) : (hi_val - quarter);
      ntc_pkg::OP_HYST: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = rep_nxt;
          out_fault_nxt = fault_new;
          out_filt_nxt  = filt_r;
        end
      end
      default: ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      count_r     <= '0;
      filt_r      <= '0;
      rep_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      filt_r      <= filt_nxt;
      out_valid_r <= out_valid_nxt;
      if ((ctrl.op == ntc_pkg::OP_HYST) && !out_busy) begin
        rep_r <= rep_nxt;
      end
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    th_r        <= th_nxt;
    blend_r     <= blend_nxt;
    out_temp_r  <= out_temp_nxt;
    out_fault_r <= out_fault_nxt;
    out_filt_r  <= out_filt_nxt;
  end

  // status to the sequencer
  always_comb begin
    stat.no_eval  = !(in_acc && (in_operation == ntc_pkg::OPN_EVAL));
    stat.cnt_zero = (count_r == '0);
    stat.div_busy = div_busy;
    stat.not_hit  = !hit;
    stat.out_busy = out_busy;
  end

  assign out_valid        = out_valid_r;
  assign out_temperature  = out_temp_r;
  assign out_fault        = out_fault_r;
  assign out_filtered_adc = out_filt_r;

endmodule

// ===== rtl/core/ntc_useq.sv =====
// microcode sequencer: step counter, program table and conditional jumps
module ntc_useq (
  input  logic           clk,
  input  logic           rst_n,
  input  ntc_pkg::stat_t stat,
  output ntc_pkg::ctrl_t ctrl
);

  ntc_pkg::step_t step_r, step_nxt;
  logic           take;

  // program: action, jump condition, jump target, fall-through step
  function automatic ntc_pkg::ctrl_t ucode(input ntc_pkg::step_t s);
    ntc_pkg::ctrl_t w;
    case (s)
      ntc_pkg::ST_IDLE:
        w = '{ntc_pkg::OP_IDLE, ntc_pkg::CND_NO_EVAL, ntc_pkg::ST_IDLE, ntc_pkg::ST_EVAL};
      ntc_pkg::ST_EVAL:
        w = '{ntc_pkg::OP_LOAD_AVG, ntc_pkg::CND_CNT_ZERO, ntc_pkg::ST_LOOK_INIT,
              ntc_pkg::ST_DIV_AVG};
      ntc_pkg::ST_DIV_AVG:
        w = '{ntc_pkg::OP_DIV_STEP, ntc_pkg::CND_DIV_BUSY, ntc_pkg::ST_DIV_AVG,
              ntc_pkg::ST_BLEND};
      ntc_pkg::ST_BLEND:
        w = '{ntc_pkg::OP_LOAD_BLEND, ntc_pkg::CND_NEVER, ntc_pkg::ST_IDLE,
              ntc_pkg::ST_FILT};
      ntc_pkg::ST_FILT:
        w = '{ntc_pkg::OP_SET_FILT, ntc_pkg::CND_NEVER, ntc_pkg::ST_IDLE,
              ntc_pkg::ST_LOOK_INIT};
      ntc_pkg::ST_LOOK_INIT:
        w = '{ntc_pkg::OP_IDX_CLR, ntc_pkg::CND_NEVER, ntc_pkg::ST_IDLE, ntc_pkg::ST_LOOK};
      ntc_pkg::ST_LOOK:
        w = '{ntc_pkg::OP_IDX_INC, ntc_pkg::CND_NOT_HIT, ntc_pkg::ST_LOOK, ntc_pkg::ST_TH};
      ntc_pkg::ST_TH:
        w = '{ntc_pkg::OP_SET_TH, ntc_pkg::CND_NEVER, ntc_pkg::ST_IDLE, ntc_pkg::ST_HYST};
      ntc_pkg::ST_HYST:
        w = '{ntc_pkg::OP_HYST, ntc_pkg::CND_OUT_BUSY, ntc_pkg::ST_HYST, ntc_pkg::ST_IDLE};
      default:
        w = '{ntc_pkg::OP_IDLE, ntc_pkg::CND_NEVER, ntc_pkg::ST_IDLE, ntc_pkg::ST_IDLE};
    endcase
    return w;
  endfunction

  // step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ntc_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // control word fetch and next step
  always_comb begin
    ctrl = ucode(step_r);
    case (ctrl.cond)
      ntc_pkg::CND_NO_EVAL:  take = stat.no_eval;
      ntc_pkg::CND_CNT_ZERO: take = stat.cnt_zero;
      ntc_pkg::CND_DIV_BUSY: take = stat.div_busy;
      ntc_pkg::CND_NOT_HIT:  take = stat.not_hit;
      ntc_pkg::CND_OUT_BUSY: take = stat.out_busy;
      default:               take = 1'b0;
    endcase
    step_nxt = take ? ctrl.tgt : ctrl.fall;
  end

endmodule

// ===== rtl/core/ntc_temperature_conversion_unit.sv =====
// top level of the ntc temperature conversion unit
//
// input channel: in_valid/in_ready with in_operation and in_adc_sample.
// a sample request (operation 0) is taken while idle and adds the reading
// to the running sum while fewer than MAX_SAMPLES readings are held.
// an evaluate request (operation 1) runs the microcode program: average by
// an iterative divider, blend and divide by five with a reciprocal
// multiply, a table search at one entry per cycle and the hysteresis
// steps. with no held samples the divider and blend are skipped. the next
// request is taken once the program is back at idle.
// result channel: out_valid/out_ready with out_temperature, out_fault and
// out_filtered_adc, one result per evaluate, held in an output register.
// while the receiver stalls, samples and a new evaluate are still taken;
// the evaluate waits at its last step until the held result is taken.
// reset (rst_n low, synchronous) clears the sum, count, filtered value,
// reported reading and the output valid flag.
module ntc_temperature_conversion_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [ntc_pkg::ADC_W-1:0]     in_adc_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ntc_pkg::TEMP_W-1:0]    out_temperature,
  output logic [ntc_pkg::FAULT_W-1:0]   out_fault,
  output logic [ntc_pkg::ADC_W-1:0]     out_filtered_adc
);

  ntc_pkg::ctrl_t ctrl;
  ntc_pkg::stat_t stat;

  ntc_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  ntc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_adc_sample    (in_adc_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_temperature  (out_temperature),
    .out_fault        (out_fault),
    .out_filtered_adc (out_filtered_adc)
  );

endmodule

// ===== rtl/core/ntc_chk.sv =====
// port-level checker for the ntc temperature conversion unit, with its bind
module ntc_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_operation,
  input logic [ntc_pkg::ADC_W-1:0]     in_adc_sample,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ntc_pkg::TEMP_W-1:0]    out_temperature,
  input logic [ntc_pkg::FAULT_W-1:0]   out_fault,
  input logic [ntc_pkg::ADC_W-1:0]     out_filtered_adc
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_temperature)
      && $stable(out_fault) && $stable(out_filtered_adc))
    else $error("stalled result changed");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an open sensor reads zero degrees
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fault == ntc_pkg::FAULT_OPEN) |-> (out_temperature == '0))
    else $error("open fault with non-zero temperature");

  // a shorted sensor reads the top temperature
  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fault == ntc_pkg::FAULT_SHORT)
      |-> (out_temperature == ntc_pkg::TEMP_W'(ntc_pkg::SHORT_TEMP)))
    else $error("short fault with wrong temperature");

  // an evaluate request starts the program and blocks the input
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == ntc_pkg::OPN_EVAL) |=> !in_ready)
    else $error("input ready right after an evaluate request");

endmodule

bind ntc_temperature_conversion_unit ntc_chk u_ntc_chk (.*);

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the ntc temperature conversion unit
`timescale 1ns / 1ps

module tb_top;

  localparam int ITEMS          = 1800;
  localparam int CALM_TAIL      = 150;
  localparam int HOLD_AT        = 50;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_TAIL       = 300;

  // one request on the input channel, with the idle gap before it
  typedef struct packed {
    logic                      op;
    logic [ntc_pkg::ADC_W-1:0] adc;
    logic [3:0]                gap;
    logic                      drain;
  } request_t;

  // one temperature reading on the result channel
  typedef struct packed {
    logic [ntc_pkg::TEMP_W-1:0] temp;
    ntc_pkg::fault_t            fault;
    logic [ntc_pkg::ADC_W-1:0]  filt;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = ntc_pkg::OPN_SAMPLE;
  logic [ntc_pkg::ADC_W-1:0] in_adc_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ntc_pkg::TEMP_W-1:0] out_temperature;
  logic [ntc_pkg::FAULT_W-1:0] out_fault;
  logic [ntc_pkg::ADC_W-1:0] out_filtered_adc;

  request_t pending_requests[$];
  reading_t expected_readings[$];

  // predicted state of the unit
  logic [ntc_pkg::SUM_W-1:0]  acc_sum = '0;
  logic [ntc_pkg::CNT_W-1:0]  acc_cnt = '0;
  logic [ntc_pkg::ADC_W-1:0]  filt_adc = '0;
  logic [ntc_pkg::TEMP_W-1:0] shown_temp = '0;

  int err_cnt = 0;
  int n_queued = 0;
  int taken_cnt = 0;
  int got_cnt = 0;
  int quiet_cycles = 0;
  logic drain_next = 1'b0;

  ntc_temperature_conversion_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_adc_sample    (in_adc_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_temperature  (out_temperature),
    .out_fault        (out_fault),
    .out_filtered_adc (out_filtered_adc)
  );

  // clock
  always #6 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %0s", $time, msg);
    err_cnt++;
  endtask

  // thermistor threshold with clamped index and bias removed
  function automatic int threshold_of(input int i);
    int k;
    k = (i >= ntc_pkg::ROM_SIZE) ? ntc_pkg::ROM_SIZE - 1 : i;
    return int'(ntc_pkg::ROM_BASE[k]) - ntc_pkg::TABLE_BIAS;
  endfunction

  function automatic logic [ntc_pkg::ADC_W-1:0] clamp_adc(input int v);
    if (v < 0) return '0;
    if (v > 1023) return '1;
    return ntc_pkg::ADC_W'(v);
  endfunction

  // accumulate a sample or turn the held samples into a reading
  task automatic convert_request(input logic op, input logic [ntc_pkg::ADC_W-1:0] adc);
    int avg;
    int idx;
    int lo;
    int hi;
    int lim;
    int f;
    reading_t r;
    if (op == ntc_pkg::OPN_SAMPLE) begin
      if (int'(acc_cnt) < ntc_pkg::MAX_SAMPLES) begin
        acc_sum = acc_sum + ntc_pkg::SUM_W'(adc);
        acc_cnt = acc_cnt + 1'b1;
      end
    end else begin
      if (acc_cnt != '0) begin
        avg = int'(acc_sum) / int'(acc_cnt);
        filt_adc = ntc_pkg::ADC_W'((2 * int'(filt_adc) + 3 * avg) / ntc_pkg::BLEND_DIV);
      end
      acc_sum = '0;
      acc_cnt = '0;
      f = int'(filt_adc);
      idx = 0;
      while (idx < ntc_pkg::TABLE_LEN && f >= threshold_of(idx)) idx++;
      r.fault = ntc_pkg::FAULT_NONE;
      if (idx == 0) begin
        shown_temp = '0;
        r.fault = ntc_pkg::FAULT_OPEN;
      end else if (idx >= ntc_pkg::TABLE_LEN) begin
        shown_temp = ntc_pkg::TEMP_W'(ntc_pkg::SHORT_TEMP);
        r.fault = ntc_pkg::FAULT_SHORT;
      end else if (idx > int'(shown_temp)) begin
        // rising: a quarter step above the held entry
        lo = threshold_of(int'(shown_temp));
        hi = threshold_of(int'(shown_temp) + 1);
        lim = (hi - lo) / 4 + lo;
        shown_temp = ntc_pkg::TEMP_W'((f >= lim) ? idx : idx - 1);
      end else if (idx < int'(shown_temp)) begin
        // falling: a quarter step below the new entry
        hi = threshold_of(idx);
        lo = threshold_of(idx - 1);
        lim = hi - (hi - lo) / 4;
        shown_temp = ntc_pkg::TEMP_W'((f <= lim) ? idx : idx + 1);
      end
      r.temp = shown_temp;
      r.filt = filt_adc;
      expected_readings.push_back(r);
    end
  endtask

  // append a request, with idle gaps in bursts and none near the end
  task automatic queue_request(input logic op, input logic [ntc_pkg::ADC_W-1:0] adc);
    request_t r;
    int pct;
    pct = (n_queued > ITEMS - CALM_TAIL || (n_queued / 150) % 3 == 1) ? 0 : 25;
    r.op = op;
    r.adc = adc;
    r.gap = (int'($urandom_range(0, 99)) < pct) ? 4'($urandom_range(1, 11)) : 4'd0;
    r.drain = drain_next;
    drain_next = 1'b0;
    pending_requests.push_back(r);
    n_queued++;
  endtask

  // driver: offer queued requests, predict each one taken
  always @(posedge clk) begin
    request_t head;
    logic nxt_valid;
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_operation <= ntc_pkg::OPN_SAMPLE;
      in_adc_sample <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        convert_request(in_operation, in_adc_sample);
        taken_cnt++;
      end
      if (!in_valid || in_ready) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          head = pending_requests[0];
          if (head.gap != 4'd0) begin
            gap_left = int'(head.gap) - 1;
            head.gap = 4'd0;
            pending_requests[0] = head;
          end else if (!head.drain || expected_readings.size() == 0) begin
            void'(pending_requests.pop_front());
            in_operation <= head.op;
            in_adc_sample <= head.adc;
            nxt_valid = 1'b1;
          end
        end
        in_valid <= nxt_valid;
      end
    end
  end

  // monitor: check readings and stall the result channel
  always @(posedge clk) begin
    reading_t want;
    logic rdy;
    int stall_left;
    int hold_left;
    bit held_once;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      held_once = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          flag_mismatch($sformatf("reading with none expected: temp %0d fault %0d adc %0d",
                                  out_temperature, out_fault, out_filtered_adc));
        end else begin
          want = expected_readings.pop_front();
          if (out_temperature !== want.temp)
            flag_mismatch($sformatf("temperature %0d, expected %0d",
                                    out_temperature, want.temp));
          if (out_fault !== want.fault)
            flag_mismatch($sformatf("fault %0d, expected %0d", out_fault, want.fault));
          if (out_filtered_adc !== want.filt)
            flag_mismatch($sformatf("filtered adc %0d, expected %0d",
                                    out_filtered_adc, want.filt));
        end
        got_cnt++;
      end
      rdy = 1'b1;
      if (!held_once && got_cnt == HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        held_once = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (pending_requests.size() > CALM_TAIL && (got_cnt / 40) % 3 != 1 &&
                   $urandom_range(0, 99) < 20) begin
        stall_left = int'($urandom_range(1, 11)) - 1;
        rdy = 1'b0;
      end
      out_ready <= rdy;
    end
  end

  // watchdog on cycles with no request or reading taken
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int pick;
    int group;
    int target;
    bit mid_drain;
    mid_drain = 1'b0;

    // directed: empty evaluate, climb to short, fall, open, bit patterns
    queue_request(ntc_pkg::OPN_EVAL, '0);
    queue_request(ntc_pkg::OPN_SAMPLE, 10'h3FF);
    queue_request(ntc_pkg::OPN_EVAL, '0);
    queue_request(ntc_pkg::OPN_SAMPLE, 10'h3FF);
    queue_request(ntc_pkg::OPN_EVAL, '1);
    queue_request(ntc_pkg::OPN_SAMPLE, 10'h3FF);
    queue_request(ntc_pkg::OPN_EVAL, '0);
    queue_request(ntc_pkg::OPN_EVAL, '0);
    queue_request(ntc_pkg::OPN_SAMPLE, '0);
    queue_request(ntc_pkg::OPN_EVAL, '0);
    queue_request(ntc_pkg::OPN_SAMPLE, 10'h155);
    queue_request(ntc_pkg::OPN_SAMPLE, 10'h2AA);
    queue_request(ntc_pkg::OPN_EVAL, '0);
    queue_request(ntc_pkg::OPN_EVAL, '0);
    queue_request(ntc_pkg::OPN_SAMPLE, '0);
    queue_request(ntc_pkg::OPN_SAMPLE, '0);
    queue_request(ntc_pkg::OPN_EVAL, '0);
    queue_request(ntc_pkg::OPN_SAMPLE, '0);
    queue_request(ntc_pkg::OPN_EVAL, '0);
    queue_request(ntc_pkg::OPN_SAMPLE, 10'd130);
    queue_request(ntc_pkg::OPN_EVAL, '0);

    // random: sample groups around a drifting level, each closed by an evaluate
    drain_next = 1'b1;
    target = int'($urandom_range(0, 1023));
    while (n_queued < ITEMS) begin
      if (n_queued >= ITEMS / 2 && !mid_drain) begin
        drain_next = 1'b1;
        mid_drain = 1'b1;
      end
      pick = int'($urandom_range(0, 99));
      if (pick < 4) group = 0;
      else if (pick < 6) group = int'($urandom_range(95, 115));
      else group = int'($urandom_range(1, 10));
      if ($urandom_range(0, 99) < 8) target = int'($urandom_range(0, 1023));
      else target = int'(clamp_adc(target + int'($urandom_range(0, 48)) - 24));
      repeat (group) begin
        if ($urandom_range(0, 9) == 0)
          queue_request(ntc_pkg::OPN_SAMPLE, ntc_pkg::ADC_W'($urandom_range(0, 1023)));
        else
          queue_request(ntc_pkg::OPN_SAMPLE,
                        clamp_adc(target + int'($urandom_range(0, 8)) - 4));
      end
      queue_request(ntc_pkg::OPN_EVAL, ntc_pkg::ADC_W'($urandom_range(0, 1023)));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (taken_cnt < n_queued || expected_readings.size() != 0) @(negedge clk);
    repeat (END_TAIL) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
